// ===== hw/rtl/srf_pkg.sv =====
// ----------------------------------------------------------------------------
// srf_pkg: shared definitions for the signal range folder
// Default sample width, fold kind codes and the per-beat control bundle.
// ----------------------------------------------------------------------------
package srf_pkg;

  localparam int SAMPLE_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    KIND_PASS  = 2'd0,
    KIND_BELOW = 2'd1,
    KIND_ABOVE = 2'd2
  } kind_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
  } ctl_t;

endpackage

// ===== hw/rtl/srf_div_step.sv =====
// ----------------------------------------------------------------------------
// srf_div_step: one restoring division step
// Shifts one numerator bit into the partial remainder, compare-subtracts the
// divisor and records the quotient bit. Bounds and control ride along.
// ----------------------------------------------------------------------------
module srf_div_step #(
  parameter int SAMPLE_WIDTH = srf_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  srf_pkg::ctl_t           in_ctl,
  input  logic [SAMPLE_WIDTH-1:0] in_lo,
  input  logic [SAMPLE_WIDTH-1:0] in_hi,
  input  logic [SAMPLE_WIDTH-1:0] in_num,
  input  logic [SAMPLE_WIDTH-1:0] in_den,
  input  logic [SAMPLE_WIDTH-1:0] in_rem,
  output srf_pkg::ctl_t           out_ctl,
  output logic [SAMPLE_WIDTH-1:0] out_lo,
  output logic [SAMPLE_WIDTH-1:0] out_hi,
  output logic [SAMPLE_WIDTH-1:0] out_num,
  output logic [SAMPLE_WIDTH-1:0] out_den,
  output logic [SAMPLE_WIDTH-1:0] out_rem,
  output logic                    out_q
);

  srf_pkg::ctl_t           ctl_r;
  logic [SAMPLE_WIDTH-1:0] lo_r, hi_r, num_r, den_r, rem_r;
  logic                    q_r;

  logic [SAMPLE_WIDTH:0]   trial;
  logic [SAMPLE_WIDTH:0]   diff;
  logic                    ge;
  logic [SAMPLE_WIDTH-1:0] rem_nxt, num_nxt;

  always_comb begin
    trial   = {in_rem, in_num[SAMPLE_WIDTH-1]};
    diff    = trial - {1'b0, in_den};
    ge      = trial >= {1'b0, in_den};
    rem_nxt = ge ? diff[SAMPLE_WIDTH-1:0] : trial[SAMPLE_WIDTH-1:0];
    num_nxt = {in_num[SAMPLE_WIDTH-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lo_r  <= in_lo;
      hi_r  <= in_hi;
      num_r <= num_nxt;
      den_r <= in_den;
      rem_r <= rem_nxt;
      q_r   <= ge;
    end
  end

  assign out_ctl = ctl_r;
  assign out_lo  = lo_r;
  assign out_hi  = hi_r;
  assign out_num = num_r;
  assign out_den = den_r;
  assign out_rem = rem_r;
  assign out_q   = q_r;

endmodule

// ===== hw/rtl/signal_range_folder.sv =====
// ----------------------------------------------------------------------------
// signal_range_folder: triangle wavefolder for a signed fixed-point stream
// Folds each sample back and forth between its two bounds.
// ----------------------------------------------------------------------------
// Takes one beat per clock and returns one beat per input beat, in order.
// Pipeline: one stage orders the bounds, one
// classifies the sample and forms distance and range, SAMPLE_WIDTH stages of
// a restoring divider each resolve one quotient bit, and an output register
// forms the folded value. The whole pipeline holds while the output beat
// waits; no beat is dropped or repeated.
module signal_range_folder #(
  parameter int SAMPLE_WIDTH = srf_pkg::SAMPLE_WIDTH_DEF,
  localparam int InDataW  = ((3 * SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int OutDataW = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // sample, low_bound, high_bound (lowest bits first), zero padded
  input  logic [InDataW-1:0]    in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // folded, zero padded
  output logic [OutDataW-1:0]   out_tdata
);

  localparam int W        = SAMPLE_WIDTH;

  logic adv;

  // stage 1: order bounds
  logic           valid1_r;
  logic [W-1:0]   x1_r, lo1_r, hi1_r;
  logic signed [W-1:0] x_in, a_in, b_in;
  logic           swap;

  // stage 2: classify
  srf_pkg::ctl_t  ctl2_r, ctl2_nxt;
  logic [W-1:0]   lo2_r, hi2_r, num2_r, den2_r;
  logic [W-1:0]   lo2_nxt, num2_nxt;
  logic [W:0]     below_d, above_d, range_d;
  logic           in_range, at_eq, is_below;

  // divider chain
  srf_pkg::ctl_t  ctl_a [0:W];
  logic [W-1:0]   lo_a  [0:W];
  logic [W-1:0]   hi_a  [0:W];
  logic [W-1:0]   num_a [0:W];
  logic [W-1:0]   den_a [0:W];
  logic [W-1:0]   rem_a [0:W];
  logic           q_a   [1:W];

  // output
  logic           out_valid_r;
  logic [W-1:0]   res_r, res_nxt;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  always_comb begin
    x_in = $signed(in_tdata[W-1:0]);
    a_in = $signed(in_tdata[2*W-1:W]);
    b_in = $signed(in_tdata[3*W-1:2*W]);
    swap = a_in > b_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
    end else if (adv) begin
      valid1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r  <= x_in;
      lo1_r <= swap ? b_in : a_in;
      hi1_r <= swap ? a_in : b_in;
    end
  end

  always_comb begin
    in_range = ($signed(x1_r) >= $signed(lo1_r)) && ($signed(x1_r) < $signed(hi1_r));
    at_eq    = lo1_r == hi1_r;
    is_below = $signed(x1_r) < $signed(lo1_r);
    below_d  = {lo1_r[W-1], lo1_r} - {x1_r[W-1], x1_r};
    above_d  = {x1_r[W-1], x1_r} - {hi1_r[W-1], hi1_r};
    range_d  = {hi1_r[W-1], hi1_r} - {lo1_r[W-1], lo1_r};
    ctl2_nxt.valid = valid1_r;
    lo2_nxt  = lo1_r;
    num2_nxt = '0;
    if (in_range) begin
      ctl2_nxt.kind = srf_pkg::KIND_PASS;
      lo2_nxt       = x1_r;
    end else if (at_eq) begin
      ctl2_nxt.kind = srf_pkg::KIND_PASS;
    end else if (is_below) begin
      ctl2_nxt.kind = srf_pkg::KIND_BELOW;
      num2_nxt      = below_d[W-1:0];
    end else begin
      ctl2_nxt.kind = srf_pkg::KIND_ABOVE;
      num2_nxt      = above_d[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else if (adv) begin
      ctl2_r <= ctl2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lo2_r  <= lo2_nxt;
      hi2_r  <= hi1_r;
      num2_r <= num2_nxt;
      den2_r <= range_d[W-1:0];
    end
  end

  assign ctl_a[0] = ctl2_r;
  assign lo_a[0]  = lo2_r;
  assign hi_a[0]  = hi2_r;
  assign num_a[0] = num2_r;
  assign den_a[0] = den2_r;
  assign rem_a[0] = '0;

  for (genvar i = 0; i < W; i++) begin : g_div
    srf_div_step #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .in_ctl  (ctl_a[i]),
      .in_lo   (lo_a[i]),
      .in_hi   (hi_a[i]),
      .in_num  (num_a[i]),
      .in_den  (den_a[i]),
      .in_rem  (rem_a[i]),
      .out_ctl (ctl_a[i+1]),
      .out_lo  (lo_a[i+1]),
      .out_hi  (hi_a[i+1]),
      .out_num (num_a[i+1]),
      .out_den (den_a[i+1]),
      .out_rem (rem_a[i+1]),
      .out_q   (q_a[i+1])
    );
  end

  always_comb begin
    case (ctl_a[W].kind)
      srf_pkg::KIND_BELOW: res_nxt = q_a[W] ? hi_a[W] - rem_a[W] : lo_a[W] + rem_a[W];
      srf_pkg::KIND_ABOVE: res_nxt = q_a[W] ? lo_a[W] + rem_a[W] : hi_a[W] - rem_a[W];
      default:             res_nxt = lo_a[W];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctl_a[W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OutDataW'(res_r);

endmodule

// ===== tb/sv/signal_range_folder_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signal_range_folder_checker: scoreboard for the signal range folder
// Watches both stream channels. For every input beat it works out the folded
// sample with exact 64-bit arithmetic and queues it. Every output beat is
// compared against the oldest queued value.
// ----------------------------------------------------------------------------
module signal_range_folder_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // sample, low_bound, high_bound (lowest bits first)
  input  logic [95:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // folded
  input  logic [31:0] out_tdata,
  output int          mismatch_count,
  output int          folds_pending
);

  localparam int SW = srf_pkg::SAMPLE_WIDTH_DEF;

  typedef struct packed {
    logic signed [SW-1:0] high_bound;
    logic signed [SW-1:0] low_bound;
    logic signed [SW-1:0] sample;
  } fold_req_t;

  logic [SW-1:0] expected_folded[$];

  function automatic logic [SW-1:0] fold_sample(fold_req_t req);
    longint x;
    longint a;
    longint b;
    longint t;
    longint y;
    longint unsigned span;
    longint unsigned excess;
    longint unsigned quo;
    longint unsigned rem;
    x = longint'(req.sample);
    a = longint'(req.low_bound);
    b = longint'(req.high_bound);
    if (a > b) begin
      t = a;
      a = b;
      b = t;
    end
    if (x >= a && x < b) begin
      y = x;
    end else if (a == b) begin
      y = a;
    end else begin
      span = longint'(b - a);
      if (x < a) begin
        excess = longint'(a - x);
        quo = excess / span;
        rem = excess % span;
        y = quo[0] ? b - longint'(rem) : a + longint'(rem);
      end else begin
        excess = longint'(x - b);
        quo = excess / span;
        rem = excess % span;
        y = quo[0] ? a + longint'(rem) : b - longint'(rem);
      end
    end
    return y[SW-1:0];
  endfunction

  initial begin
    mismatch_count = 0;
    folds_pending = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_folded.size() == 0) begin
          $display("%0t unexpected folded beat: expected none actual %0d", $time,
                   $signed(out_tdata));
          mismatch_count <= mismatch_count + 1;
        end else begin
          if (out_tdata !== expected_folded[0]) begin
            $display("%0t folded mismatch: expected %0d actual %0d", $time,
                     $signed(expected_folded[0]), $signed(out_tdata));
            mismatch_count <= mismatch_count + 1;
          end
          void'(expected_folded.pop_front());
        end
      end
      if (in_tvalid && in_tready) begin
        expected_folded.push_back(fold_sample(fold_req_t'(in_tdata)));
      end
      folds_pending <= expected_folded.size();
    end
  end

endmodule

// ===== tb/sv/tb_signal_range_folder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signal_range_folder: testbench for the signal range folder
// Sends directed corner samples, then random samples with bounds of all sizes,
// under random idle bursts on both channels. The checker predicts and
// compares; this module drives stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_signal_range_folder;

  localparam int SW = srf_pkg::SAMPLE_WIDTH_DEF;
  localparam int RANDOM_BEATS = 2000;
  localparam int CALM_BEATS = 200;
  localparam int DRAIN_CYCLES = 2 * (SW + 3) + 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IMIN = 32'h8000_0000;
  localparam int IMAX = 32'h7fff_ffff;
  localparam int ONE = 32'h0001_0000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        calm = 1'b0;
  int          mismatch_count;
  int          folds_pending;
  int          cycle_count = 0;
  int          gap_pct = 0;
  int          stall_left = 0;
  int          run_left = 0;

  always #5 clk = ~clk;

  signal_range_folder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  signal_range_folder_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .folds_pending  (folds_pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // hold off the output side in random bursts
  always @(posedge clk) begin
    if (calm) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (run_left > 0) begin
      out_tready <= 1'b1;
      run_left <= run_left - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 15);
    end else begin
      out_tready <= 1'b1;
      run_left <= $urandom_range(0, 60);
    end
  end

  task automatic send_fold(input logic [SW-1:0] smp, input logic [SW-1:0] lo,
                           input logic [SW-1:0] hi);
    in_tdata <= {hi, lo, smp};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (!calm && $urandom_range(1, 100) <= gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic send_random_fold();
    logic [SW-1:0] smp;
    logic [SW-1:0] lo;
    logic [SW-1:0] hi;
    logic [SW-1:0] span;
    int            pick;
    pick = $urandom_range(0, 99);
    smp = $urandom;
    lo = $urandom;
    hi = $urandom;
    if (pick < 35) begin
      // full-range values
    end else if (pick < 75) begin
      span = $urandom_range(1, 1 << $urandom_range(0, 24));
      hi = lo + span;
      smp = lo + $signed($urandom_range(0, 8 * span)) - $signed(4 * span);
    end else if (pick < 88) begin
      hi = lo;
    end else begin
      span = $urandom_range(1, 1 << $urandom_range(0, 30));
      hi = lo + span;
      case ($urandom_range(0, 3))
        0: smp = lo;
        1: smp = hi;
        2: smp = lo - 1;
        default: smp = hi - 1;
      endcase
    end
    if ($urandom_range(0, 1) == 1) begin
      send_fold(smp, hi, lo);
    end else begin
      send_fold(smp, lo, hi);
    end
  endtask

  initial begin
    int corner[20][3];
    corner = '{
      '{0, -ONE, ONE},
      '{ONE, -ONE, ONE},
      '{-ONE, -ONE, ONE},
      '{0, ONE, -ONE},
      '{12345, 7 * ONE, 7 * ONE},
      '{-3 * ONE, -ONE, ONE},
      '{-2 * ONE, -ONE, ONE},
      '{3 * ONE, -ONE, ONE},
      '{5 * ONE / 2, -ONE, ONE},
      '{IMIN, IMAX, IMIN},
      '{IMAX, IMIN, IMAX},
      '{IMIN, IMAX, IMAX},
      '{IMIN, IMAX - 1, IMAX},
      '{IMAX, IMIN, IMIN + 1},
      '{IMAX, IMIN, IMIN},
      '{IMIN, 0, 1},
      '{-1, 0, 0},
      '{IMAX, -3, 5},
      '{IMIN, -3, 5},
      '{1, 1, 0}
    };
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gap_pct = 30;
    foreach (corner[i]) begin
      send_fold(corner[i][0], corner[i][1], corner[i][2]);
    end
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 50;
        endcase
      end
      if (n == RANDOM_BEATS - CALM_BEATS) begin
        calm <= 1'b1;
      end
      send_random_fold();
    end
    in_tvalid <= 1'b0;
    while (folds_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && folds_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/srf_pkg.sv
hw/rtl/srf_div_step.sv
hw/rtl/signal_range_folder.sv
tb/sv/signal_range_folder_checker.sv
tb/sv/tb_signal_range_folder.sv
